>>> rtl/core/lrt_pkg.sv
// Shared types, constants and the sigmoid table for the logistic regression trainer.
// No dependencies; every other file imports this package.
package lrt_pkg;

  localparam int SIG_ENTRIES = 1024;
  localparam int SIG_AW      = $clog2(SIG_ENTRIES);
  localparam int SIG_SHIFT   = 20 - SIG_AW;   // z range [-8,8) in Q16 spans 2^20
  localparam int Z_W         = 42;
  localparam int GRAD_W      = 48;
  localparam int ERR_W       = 18;
  localparam int MUL_AW      = 33;
  localparam int MUL_BW      = 25;
  localparam int MUL_PW      = MUL_AW + MUL_BW;
  localparam int ACC_W       = 64;

  localparam logic [1:0] MODE_LOAD_TRAIN = 2'd0;
  localparam logic [1:0] MODE_LOAD_TEST  = 2'd1;
  localparam logic [1:0] MODE_RUN        = 2'd2;

  localparam logic [0:0] REG_LEARNING_RATE = 1'd0;
  localparam logic [0:0] REG_ITERATIONS    = 1'd1;

  localparam logic signed [31:0] W_ONE = 32'sd65536;

  typedef logic [16:0] sig_entry_t;
  typedef sig_entry_t sig_tbl_t [SIG_ENTRIES];

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] feature;
    logic       label;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] bias_weight;
    logic signed [31:0] feature_weight;
    logic [8:0]         true_positives;
    logic [8:0]         true_negatives;
    logic [8:0]         false_positives;
    logic [8:0]         false_negatives;
    logic               overflow_flag;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_IT_CHECK, ST_TR_CHECK, ST_TR_Z, ST_TR_SIG, ST_TR_ERR, ST_TR_GX,
    ST_U_LO, ST_U_HI, ST_U_APPLY, ST_TE_CHECK, ST_TE_Z, ST_TE_CLS, ST_DONE
  } state_t;

  // Unsigned restoring division, used only while the table is built
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-f in Q30 for f in [0,1] (Q16), 17-term Taylor series
  function automatic longint exp_series_q30(longint f_q16);
    longint unsigned fq;
    longint unsigned term;
    longint          sum;
    fq   = longint'(f_q16) << 14;
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    for (int n = 1; n <= 16; n++) begin
      term = udiv64((term * fq) >> 30, longint'(n));
      if ((n & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
    return sum;
  endfunction

  function automatic longint exp_neg_q30(longint t_q16);
    longint e1;
    longint r;
    longint n;
    e1 = exp_series_q30(64'sd65536);
    r  = exp_series_q30(t_q16 & 64'sd65535);
    n  = t_q16 >>> 16;
    for (int i = 0; i < 8; i++) begin
      if (longint'(i) < n) r = (r * e1) >>> 30;
    end
    return r;
  endfunction

  function automatic sig_tbl_t build_sig_table();
    sig_tbl_t t;
    longint   half;
    longint   x;
    longint   ax;
    longint   e;
    longint   d;
    longint   num;
    half = 64'sd8 * 64'sd65536;
    for (int k = 0; k < SIG_ENTRIES; k++) begin
      x   = -half + ((64'sd2 * longint'(k) + 64'sd1) * half) / SIG_ENTRIES;
      ax  = (x >= 0) ? x : -x;
      e   = exp_neg_q30(ax);
      d   = (64'sd1 << 30) + e;
      num = (x >= 0) ? (64'sd1 << 46) : (e << 16);
      t[k] = sig_entry_t'(udiv64(num + d / 2, d));
    end
    return t;
  endfunction

  localparam sig_tbl_t SIG_TABLE = build_sig_table();

endpackage

>>> rtl/core/logistic_regression_trainer_top.sv
// Top level of the logistic regression trainer: row stores, sequencer, shared multiplier.
// Depends on lrt_pkg and lrt_sigmoid.
//
// Usage: a transaction with mode 0 or 1 stores one training or test row; a full store
// drops the row and raises overflow_flag on the next run. A run transaction (mode 2)
// trains from both weights at 1.0 and then scores the test rows. busy stays high for
// the whole run: each training row passes through the one shared multiplier path
// (store read, w1*x, registered sigmoid lookup, error, x*err), each iteration adds one
// iteration check and one closing row check, each weight update two partial products
// of the step size against the gradient plus one apply step, and each test row a check,
// a w1*x product and a classification.
// The result shows on out_data for exactly one cycle with out_valid high; the receiver
// cannot stall it, so take it then. A run empties both row stores. Configuration writes
// belong in idle time only.
module logistic_regression_trainer_top import lrt_pkg::*; #(
  parameter int TRAIN_DEPTH = 1024,
  parameter int TEST_DEPTH  = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_data,
  output logic       out_valid,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int TRAIN_AW = (TRAIN_DEPTH > 1) ? $clog2(TRAIN_DEPTH) : 1;
  localparam int TEST_AW  = (TEST_DEPTH > 1) ? $clog2(TEST_DEPTH) : 1;
  localparam int TRAIN_CW = $clog2(TRAIN_DEPTH + 1);
  localparam int TEST_CW  = $clog2(TEST_DEPTH + 1);

  state_t state_r, state_nxt;

  logic [15:0] lr_r, iters_r, it_r;
  logic [TRAIN_CW-1:0] train_rows_r, tr_idx_r;
  logic [TEST_CW-1:0]  test_rows_r, te_idx_r;
  logic dropped_r;

  // Row stores: feature in [8:1], label in [0]
  logic [8:0] train_mem [TRAIN_DEPTH];
  logic [8:0] test_mem  [TEST_DEPTH];
  logic [8:0] train_rd_r, test_rd_r;

  logic signed [31:0] w0_r, w1_r;
  logic signed [GRAD_W-1:0] g0_r, g1_r;
  logic signed [ERR_W-1:0] err_r;
  logic signed [MUL_PW-1:0] prod_r;
  logic [ACC_W-1:0] acc_r;
  logic upd_sel_r;
  logic [8:0] tp_r, tn_r, fp_r, fn_r;
  logic out_valid_r;
  out_item_t out_r;

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // Shared multiplier with operand select by sequencer state
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p;
  logic signed [GRAD_W-1:0] g_sel;
  logic [GRAD_W-1:0] g_mag;
  logic [7:0] tr_feat;

  assign tr_feat = train_rd_r[8:1];
  assign g_sel = upd_sel_r ? g1_r : g0_r;
  assign g_mag = g_sel[GRAD_W-1] ? GRAD_W'(-g_sel) : GRAD_W'(g_sel);

  always_comb begin
    mul_a = MUL_AW'(w1_r);
    mul_b = MUL_BW'({1'b0, tr_feat});
    unique case (state_r)
      ST_TE_Z: begin
        mul_a = MUL_AW'(w1_r);
        mul_b = MUL_BW'({1'b0, test_rd_r[8:1]});
      end
      ST_TR_GX: begin
        mul_a = MUL_AW'(err_r);
        mul_b = MUL_BW'({1'b0, tr_feat});
      end
      ST_U_LO: begin
        mul_a = MUL_AW'({1'b0, lr_r});
        mul_b = MUL_BW'({1'b0, g_mag[23:0]});
      end
      ST_U_HI: begin
        mul_a = MUL_AW'({1'b0, lr_r});
        mul_b = MUL_BW'({1'b0, g_mag[47:24]});
      end
      default: begin
      end
    endcase
    mul_p = MUL_PW'(mul_a) * MUL_PW'(mul_b);
  end

  // z = w0 + w1*x from the registered product; the registered sigmoid answer follows in the next cycle
  logic signed [Z_W-1:0] z_cur;
  sig_entry_t sig_p;
  logic signed [ERR_W-1:0] err_nxt;
  logic label_cur;

  assign z_cur = Z_W'(w0_r) + prod_r[Z_W-1:0];
  assign label_cur = train_rd_r[0];
  assign err_nxt = ERR_W'({1'b0, label_cur, 16'b0}) - ERR_W'({1'b0, sig_p});

  lrt_sigmoid u_sigmoid (
    .clk (clk),
    .z   (z_cur),
    .p   (sig_p)
  );

  // Weight update: round the scaled magnitude, restore the sign, saturate
  logic signed [49:0] delta, w_sum;
  logic signed [31:0] w_new;

  always_comb begin
    delta = 50'(acc_r[63:16]);
    if (g_sel[GRAD_W-1]) delta = -delta;
    w_sum = 50'(upd_sel_r ? w1_r : w0_r) + delta;
    if (w_sum > 50'sd2147483647) w_new = 32'sh7fffffff;
    else if (w_sum < -50'sd2147483648) w_new = 32'sh80000000;
    else w_new = w_sum[31:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (accept && in_data.mode == MODE_RUN) state_nxt = ST_IT_CHECK;
      ST_IT_CHECK: state_nxt = (it_r == iters_r) ? ST_TE_CHECK : ST_TR_CHECK;
      ST_TR_CHECK: state_nxt = (tr_idx_r == train_rows_r) ? ST_U_LO : ST_TR_Z;
      ST_TR_Z:     state_nxt = ST_TR_SIG;
      ST_TR_SIG:   state_nxt = ST_TR_ERR;
      ST_TR_ERR:   state_nxt = ST_TR_GX;
      ST_TR_GX:    state_nxt = ST_TR_CHECK;
      ST_U_LO:     state_nxt = ST_U_HI;
      ST_U_HI:     state_nxt = ST_U_APPLY;
      ST_U_APPLY:  state_nxt = upd_sel_r ? ST_IT_CHECK : ST_U_LO;
      ST_TE_CHECK: state_nxt = (te_idx_r == test_rows_r) ? ST_DONE : ST_TE_Z;
      ST_TE_Z:     state_nxt = ST_TE_CLS;
      ST_TE_CLS:   state_nxt = ST_TE_CHECK;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Row stores: write on load, registered read at the walk index
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept && in_data.mode == MODE_LOAD_TRAIN &&
        train_rows_r < TRAIN_CW'(TRAIN_DEPTH)) begin
      train_mem[train_rows_r[TRAIN_AW-1:0]] <= {in_data.feature, in_data.label};
    end
    if (state_r == ST_IDLE && accept && in_data.mode == MODE_LOAD_TEST &&
        test_rows_r < TEST_CW'(TEST_DEPTH)) begin
      test_mem[test_rows_r[TEST_AW-1:0]] <= {in_data.feature, in_data.label};
    end
    train_rd_r <= train_mem[tr_idx_r[TRAIN_AW-1:0]];
    test_rd_r  <= test_mem[te_idx_r[TEST_AW-1:0]];
  end

  // Control counters and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r         <= 16'd66;
      iters_r      <= 16'd100;
      train_rows_r <= '0;
      test_rows_r  <= '0;
      dropped_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      it_r         <= '0;
      tr_idx_r     <= '0;
      te_idx_r     <= '0;
      upd_sel_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LEARNING_RATE: lr_r <= cfg_data;
          REG_ITERATIONS:    iters_r <= cfg_data;
          default: begin
          end
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            priority case (in_data.mode)
              MODE_LOAD_TRAIN: begin
                if (train_rows_r < TRAIN_CW'(TRAIN_DEPTH)) train_rows_r <= train_rows_r + 1'b1;
                else dropped_r <= 1'b1;
              end
              MODE_LOAD_TEST: begin
                if (test_rows_r < TEST_CW'(TEST_DEPTH)) test_rows_r <= test_rows_r + 1'b1;
                else dropped_r <= 1'b1;
              end
              MODE_RUN: begin
                it_r     <= '0;
                tr_idx_r <= '0;
                te_idx_r <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_IT_CHECK: begin
          tr_idx_r  <= '0;
          upd_sel_r <= 1'b0;
        end
        ST_TR_GX: tr_idx_r <= tr_idx_r + 1'b1;
        ST_U_APPLY: begin
          upd_sel_r <= ~upd_sel_r;
          if (upd_sel_r) it_r <= it_r + 1'b1;
        end
        ST_TE_CLS: te_idx_r <= te_idx_r + 1'b1;
        ST_DONE: begin
          out_valid_r  <= 1'b1;
          train_rows_r <= '0;
          test_rows_r  <= '0;
          dropped_r    <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        w0_r <= W_ONE;
        w1_r <= W_ONE;
        tp_r <= '0;
        tn_r <= '0;
        fp_r <= '0;
        fn_r <= '0;
      end
      ST_IT_CHECK: begin
        g0_r <= '0;
        g1_r <= '0;
      end
      ST_TR_Z, ST_TE_Z: prod_r <= mul_p;
      ST_TR_ERR: begin
        err_r <= err_nxt;
        g0_r  <= g0_r + GRAD_W'(err_nxt);
      end
      ST_TR_GX: g1_r <= g1_r + GRAD_W'(mul_p);
      ST_U_LO: acc_r <= ACC_W'(mul_p[39:0]) + ACC_W'(32768);
      ST_U_HI: acc_r <= acc_r + (ACC_W'(mul_p[39:0]) << 24);
      ST_U_APPLY: begin
        if (upd_sel_r) w1_r <= w_new;
        else w0_r <= w_new;
      end
      ST_TE_CLS: begin
        // predict 1 when z > 0
        priority if (z_cur > 0 && test_rd_r[0]) tp_r <= tp_r + 1'b1;
        else if (!(z_cur > 0) && !test_rd_r[0]) tn_r <= tn_r + 1'b1;
        else if (z_cur > 0) fp_r <= fp_r + 1'b1;
        else fn_r <= fn_r + 1'b1;
      end
      ST_DONE: begin
        out_r.bias_weight     <= w0_r;
        out_r.feature_weight  <= w1_r;
        out_r.true_positives  <= tp_r;
        out_r.true_negatives  <= tn_r;
        out_r.false_positives <= fp_r;
        out_r.false_negatives <= fn_r;
        out_r.overflow_flag   <= dropped_r;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/lrt_sigmoid.sv
// Sigmoid lookup: maps z (Q16) to a table index and returns p in Q1.16 from a registered table read.
// Depends on lrt_pkg for the table and widths.
module lrt_sigmoid import lrt_pkg::*; (
  input  logic                  clk,
  input  logic signed [Z_W-1:0] z,
  output sig_entry_t            p
);

  logic signed [Z_W:0] s;
  logic [Z_W:0]        pos;
  logic [SIG_AW-1:0]   idx;
  sig_entry_t          p_r;

  assign p = p_r;

  always_comb begin
    s   = (Z_W+1)'(z) + (Z_W+1)'(64'sd524288);
    pos = (Z_W+1)'(s) >> SIG_SHIFT;
    if (s < 0) begin
      idx = '0;
    end else if (pos > (Z_W+1)'(SIG_ENTRIES - 1)) begin
      idx = SIG_AW'(SIG_ENTRIES - 1);
    end else begin
      idx = pos[SIG_AW-1:0];
    end
  end

  // registered table read
  always_ff @(posedge clk) begin
    p_r <= SIG_TABLE[idx];
  end

endmodule

>>> sim/logistic_regression_trainer_top_tb.sv
// Self-checking testbench for logistic_regression_trainer_top: row loads, runs, config.
// Depends on lrt_pkg (port types, mode and register codes) and the block's RTL.
module logistic_regression_trainer_top_tb import lrt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int TRAIN_CAP = 1024;
  localparam int TEST_CAP  = 256;
  localparam int LUT_SIZE  = 1024;
  localparam int STALL_LIMIT = 2_000_000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  logistic_regression_trainer_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: its own copy of the row stores, the counters and the registers.
  logic [16:0] logistic_lut [LUT_SIZE];
  logic [7:0]  train_feat [TRAIN_CAP];
  logic        train_lab  [TRAIN_CAP];
  logic [7:0]  test_feat  [TEST_CAP];
  logic        test_lab   [TEST_CAP];
  int          n_train;
  int          n_test;
  logic        row_dropped;
  logic [15:0] step_size;
  logic [15:0] n_iters;

  out_item_t   pending_runs [$];
  int          fail_count;
  int          idle_pct;
  int          stall_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // e^-f in Q30 for f in [0,1] given in Q16, truncated Taylor series
  function automatic longint exp_frac_q30(longint f_q16);
    longint unsigned arg;
    longint unsigned term;
    longint          acc;
    arg  = longint'(f_q16) << 14;
    term = 64'd1 << 30;
    acc  = 64'sd1 << 30;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * arg) >> 30) / n;
      acc  = n[0] ? acc - longint'(term) : acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
    return acc;
  endfunction

  // Fill the sigmoid lookup: cell centers over [-8,8), rounded to Q1.16.
  task automatic fill_logistic_lut();
    longint half, x, ax, e, d, num, e1;
    half = 64'sd8 * 64'sd65536;
    e1   = exp_frac_q30(64'sd65536);
    for (int k = 0; k < LUT_SIZE; k++) begin
      x  = -half + ((2 * longint'(k) + 1) * half) / LUT_SIZE;
      ax = (x >= 0) ? x : -x;
      e  = exp_frac_q30(ax & 64'hFFFF);
      for (longint i = 0; i < (ax >>> 16); i++) e = (e * e1) >>> 30;
      d   = (64'sd1 << 30) + e;
      num = (x >= 0) ? (64'sd1 << 46) : (e << 16);
      logistic_lut[k] = 17'((num + d / 2) / d);
    end
  endtask

  function automatic longint logistic_of(longint z);
    longint s, idx;
    s = z + 64'sd8 * 64'sd65536;
    if (s < 0) return longint'(logistic_lut[0]);
    idx = (s * LUT_SIZE) / (64'sd16 * 64'sd65536);
    if (idx > LUT_SIZE - 1) idx = LUT_SIZE - 1;
    return longint'(logistic_lut[idx]);
  endfunction

  function automatic longint weight_step(longint grad);
    longint unsigned mag, p;
    mag = (grad < 0) ? -grad : grad;
    p   = (longint'(step_size) * mag + 32768) >> 16;
    return (grad < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Train from 1.0/1.0, score the test rows, then empty the stores.
  function automatic out_item_t train_and_score();
    out_item_t r;
    longint w0, w1, g0, g1, x, z, err;
    int tp, tn, fp, fn;
    w0 = 65536;
    w1 = 65536;
    tp = 0; tn = 0; fp = 0; fn = 0;
    for (int it = 0; it < n_iters; it++) begin
      g0 = 0;
      g1 = 0;
      for (int i = 0; i < n_train; i++) begin
        x   = train_feat[i];
        z   = w0 + w1 * x;
        err = (train_lab[i] ? 64'sd65536 : 64'sd0) - logistic_of(z);
        g0 += err;
        g1 += x * err;
      end
      w0 = clip32(w0 + weight_step(g0));
      w1 = clip32(w1 + weight_step(g1));
    end
    for (int i = 0; i < n_test; i++) begin
      z = w0 + w1 * longint'(test_feat[i]);
      if (z > 0 && test_lab[i]) tp++;
      else if (!(z > 0) && !test_lab[i]) tn++;
      else if (z > 0) fp++;
      else fn++;
    end
    r.bias_weight     = 32'(w0);
    r.feature_weight  = 32'(w1);
    r.true_positives  = 9'(tp);
    r.true_negatives  = 9'(tn);
    r.false_positives = 9'(fp);
    r.false_negatives = 9'(fn);
    r.overflow_flag   = row_dropped;
    n_train     = 0;
    n_test      = 0;
    row_dropped = 1'b0;
    return r;
  endfunction

  // Advance the predictor by one accepted transaction.
  task automatic predict_item(in_item_t item);
    case (item.mode)
      MODE_LOAD_TRAIN: begin
        if (n_train < TRAIN_CAP) begin
          train_feat[n_train] = item.feature;
          train_lab[n_train]  = item.label;
          n_train++;
        end else begin
          row_dropped = 1'b1;
        end
      end
      MODE_LOAD_TEST: begin
        if (n_test < TEST_CAP) begin
          test_feat[n_test] = item.feature;
          test_lab[n_test]  = item.label;
          n_test++;
        end else begin
          row_dropped = 1'b1;
        end
      end
      MODE_RUN: pending_runs.insert(pending_runs.size(), train_and_score());
      default: ;
    endcase
  endtask

  // Send one transaction: wait out random idle cycles and any busy time, then raise start.
  task automatic send_item(logic [1:0] mode, logic [7:0] feature, logic label);
    in_item_t item;
    item.mode    = mode;
    item.feature = feature;
    item.label   = label;
    @(negedge clk);
    while (busy || $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    predict_item(item);
  endtask

  // Drop start and wait for every run result plus the block's trailing cycles.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_runs.size() == 0);
    repeat (8) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] index, logic [15:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (index == REG_LEARNING_RATE) step_size = value;
    else n_iters = value;
  endtask

  task automatic report_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Check each run result against the oldest pending prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_runs.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %p", $time, out_data);
        fail_count++;
      end else begin
        out_item_t want;
        want = pending_runs.pop_front();
        report_field("bias_weight", want.bias_weight, out_data.bias_weight);
        report_field("feature_weight", want.feature_weight, out_data.feature_weight);
        report_field("true_positives", want.true_positives, out_data.true_positives);
        report_field("true_negatives", want.true_negatives, out_data.true_negatives);
        report_field("false_positives", want.false_positives, out_data.false_positives);
        report_field("false_negatives", want.false_negatives, out_data.false_negatives);
        report_field("overflow_flag", want.overflow_flag, out_data.overflow_flag);
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Empty stores, the unused mode, and both counters on a run with nothing loaded.
  task automatic test_empty_sets();
    send_item(MODE_RUN, 8'h00, 1'b0);
    send_item(MODE_UNUSED, 8'hFF, 1'b1);
    send_item(MODE_LOAD_TEST, 8'h80, 1'b1);
    send_item(MODE_RUN, 8'hFF, 1'b1);
    send_item(MODE_LOAD_TRAIN, 8'h7F, 1'b0);
    send_item(MODE_RUN, 8'h55, 1'b0);
  endtask

  task automatic load_corner_rows();
    send_item(MODE_LOAD_TRAIN, 8'h00, 1'b0);
    send_item(MODE_LOAD_TRAIN, 8'hFF, 1'b1);
    send_item(MODE_LOAD_TRAIN, 8'hFF, 1'b0);
    send_item(MODE_LOAD_TRAIN, 8'h00, 1'b1);
    send_item(MODE_LOAD_TEST, 8'h00, 1'b0);
    send_item(MODE_LOAD_TEST, 8'hFF, 1'b1);
    send_item(MODE_LOAD_TEST, 8'h01, 1'b1);
  endtask

  // Register extremes: max and zero step, zero and max iteration counts.
  task automatic test_register_extremes();
    write_reg(REG_LEARNING_RATE, 16'hFFFF);
    write_reg(REG_ITERATIONS, 16'd3);
    load_corner_rows();
    send_item(MODE_RUN, 8'h00, 1'b0);
    write_reg(REG_LEARNING_RATE, 16'd0);
    load_corner_rows();
    send_item(MODE_RUN, 8'h00, 1'b0);
    write_reg(REG_LEARNING_RATE, 16'd66);
    write_reg(REG_ITERATIONS, 16'd0);
    load_corner_rows();
    send_item(MODE_RUN, 8'h00, 1'b0);
    // keep the training set empty so the longest iteration count stays cheap
    write_reg(REG_ITERATIONS, 16'hFFFF);
    send_item(MODE_LOAD_TEST, 8'h10, 1'b1);
    send_item(MODE_RUN, 8'h00, 1'b0);
  endtask

  // Fill the test store one past capacity: the extra row drops and sets the overflow flag.
  task automatic test_full_stores();
    write_reg(REG_ITERATIONS, 16'd1);
    for (int i = 0; i < 4; i++)
      send_item(MODE_LOAD_TRAIN, 8'($urandom), 1'($urandom));
    for (int i = 0; i <= TEST_CAP; i++)
      send_item(MODE_LOAD_TEST, 8'($urandom), 1'($urandom));
    send_item(MODE_RUN, 8'h00, 1'b0);
    send_item(MODE_LOAD_TEST, 8'h20, 1'b0);
    send_item(MODE_RUN, 8'h00, 1'b0);
  endtask

  // Mostly well-formed batches (rows then a run) with some noise and stray runs.
  task automatic test_random_batches(int item_budget);
    int sent, rows, kind;
    sent = 0;
    while (sent < item_budget) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        write_reg(REG_LEARNING_RATE, 16'($urandom));
      end else if (kind == 1) begin
        write_reg(REG_ITERATIONS, 16'($urandom_range(20, 1)));
      end else if (kind == 2) begin
        write_reg(REG_LEARNING_RATE, $urandom_range(1) ? 16'hFFFF : 16'd0);
      end
      rows = $urandom_range(40);
      for (int i = 0; i < rows; i++) begin
        kind = $urandom_range(99);
        if (kind < 60) send_item(MODE_LOAD_TRAIN, 8'($urandom), 1'($urandom));
        else if (kind < 95) send_item(MODE_LOAD_TEST, 8'($urandom), 1'($urandom));
        else send_item(MODE_UNUSED, 8'($urandom), 1'($urandom));
      end
      send_item(MODE_RUN, 8'($urandom), 1'($urandom));
      sent += rows + 1;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_LEARNING_RATE;
    cfg_data  = '0;
    fail_count   = 0;
    idle_pct     = 28;
    n_train      = 0;
    n_test       = 0;
    row_dropped  = 1'b0;
    step_size    = 16'd66;
    n_iters      = 16'd100;
    fill_logistic_lut();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_sets();
    test_register_extremes();
    test_full_stores();
    write_reg(REG_ITERATIONS, 16'd6);
    idle_pct = 28;
    test_random_batches(190);
    idle_pct = 85;
    test_random_batches(180);
    idle_pct = 0;
    test_random_batches(180);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
